// ----- sv/isl_pkg.sv -----
package isl_pkg;

    // Default build values
    localparam int MAX_NAME_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF    = 25;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 25;

    // Name bytes held by the two name registers
    localparam int NAME_REG_BYTES = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_JUNK     = 2'd3;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;

    // One processed word: advance strobe and end-of-file flag
    typedef struct packed {
        logic adv;
        logic last;
    } t_step;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    offset;
        logic [OUT_W-1:0]    length;
    } t_result;

endpackage

// ----- sv/isl_match.sv -----
module isl_match #(
    parameter int MAX_NAME_BYTES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  isl_pkg::t_step              i_step,
    input  logic [isl_pkg::BYTE_W-1:0]  i_byte,
    input  logic [isl_pkg::LEN_W-1:0]   i_name_len,
    input  logic [isl_pkg::CFG_W-1:0]   i_name_low,
    input  logic [isl_pkg::CFG_W-1:0]   i_name_high,
    output logic                        o_hit
);
    import isl_pkg::*;

    localparam int LW = $clog2(MAX_NAME_BYTES + 1);

    // Lower-case ASCII letters only
    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // r_hist[k]: the last k+1 words spell '[' followed by name bytes 0..k-1
    logic [MAX_NAME_BYTES:0]   r_hist;
    logic [MAX_NAME_BYTES:0]   n_hist;
    logic [MAX_NAME_BYTES-1:0] w_eq;
    logic [LW-1:0]             w_len_eff;

    // Per-position compare of the incoming byte against each name byte
    for (genvar k = 0; k < MAX_NAME_BYTES; k++) begin : g_eq
        if (k < 8) begin : g_low
            assign w_eq[k] = fold(i_byte) == fold(i_name_low[8*k +: 8]);
        end else if (k < NAME_REG_BYTES) begin : g_high
            assign w_eq[k] = fold(i_byte) == fold(i_name_high[8*(k-8) +: 8]);
        end else begin : g_zero
            assign w_eq[k] = i_byte == '0;
        end
    end

    // Lengths past the window act as the full window
    assign w_len_eff = (int'(i_name_len) > MAX_NAME_BYTES) ? LW'(MAX_NAME_BYTES)
                                                           : LW'(i_name_len);

    // Header closes on ']' right after '[' + name
    assign o_hit = (w_len_eff != '0) && (i_byte == CH_RBRACKET) && r_hist[w_len_eff];

    always_comb begin
        n_hist = r_hist;
        if (i_step.adv) begin
            if (i_step.last) begin
                n_hist = '0;
            end else begin
                n_hist = {r_hist[MAX_NAME_BYTES-1:0] & w_eq, i_byte == CH_LBRACKET};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= n_hist;
        end
    end

endmodule

// ----- sv/isl_track.sv -----
module isl_track #(
    parameter int OFFSET_BITS = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  isl_pkg::t_step             i_step,
    input  logic [isl_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_hit,
    input  logic                       i_name_empty,
    output isl_pkg::t_result           o_result
);
    import isl_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SKIP1,
        PH_SPACES,
        PH_CRLF,
        PH_BODY,
        PH_DONE,
        PH_JUNK
    } t_phase;

    localparam int OB = OFFSET_BITS;

    // Saturating add of a small step
    function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] v, input logic [1:0] d);
        logic [OB:0] s;
        s = {1'b0, v} + (OB+1)'(d);
        return s[OB] ? {OB{1'b1}} : s[OB-1:0];
    endfunction

    t_phase        r_phase, n_phase, w_phase;
    logic [OB-1:0] r_pos, n_pos;
    logic [OB-1:0] r_start, n_start, w_start;
    logic [OB-1:0] r_count, n_count, w_count;
    logic [OB-1:0] w_inc1, w_inc2;
    logic          w_crlf;
    t_result       w_res;

    assign w_inc1 = sat_add(r_pos, 2'd1);
    assign w_inc2 = sat_add(r_pos, 2'd2);
    assign w_crlf = (i_byte == CH_CR) || (i_byte == CH_LF);

    // Phase walk for the current word
    always_comb begin
        w_phase = r_phase;
        w_start = r_start;
        w_count = r_count;
        case (r_phase)
            PH_SEARCH: begin
                if (i_hit) begin
                    w_start = w_inc2;
                    w_phase = PH_SKIP1;
                end
            end
            PH_SKIP1: begin
                w_phase = PH_SPACES;
            end
            PH_SPACES: begin
                if (i_byte == CH_SPACE) begin
                    w_start = w_inc1;
                end else if (w_crlf) begin
                    w_start = w_inc1;
                    w_phase = PH_CRLF;
                end else begin
                    w_phase = PH_JUNK;
                end
            end
            PH_CRLF: begin
                if (w_crlf) begin
                    w_start = w_inc1;
                end else begin
                    w_start = r_pos;
                    if (i_byte == CH_LBRACKET) begin
                        w_phase = PH_DONE;
                    end else begin
                        w_count = OB'(1);
                        w_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (i_byte == CH_LBRACKET) begin
                    w_phase = PH_DONE;
                end else begin
                    w_count = sat_add(r_count, 2'd1);
                end
            end
            default: begin
            end
        endcase
    end

    // Result as seen at end of file
    always_comb begin
        w_res.status = ST_FOUND;
        w_res.offset = '0;
        w_res.length = '0;
        case (w_phase)
            PH_SEARCH: w_res.status = i_name_empty ? ST_EMPTY : ST_NOTFOUND;
            PH_JUNK:   w_res.status = ST_JUNK;
            PH_BODY, PH_DONE: begin
                w_res.offset = OUT_W'(w_start);
                w_res.length = OUT_W'(w_count);
            end
            default: begin
                w_res.offset = OUT_W'(w_start);
            end
        endcase
    end

    assign o_result = w_res;

    // Commit, or start over after the last word
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_start = r_start;
        n_count = r_count;
        if (i_step.adv) begin
            if (i_step.last) begin
                n_phase = PH_SEARCH;
                n_pos   = '0;
                n_start = '0;
                n_count = '0;
            end else begin
                n_phase = w_phase;
                n_pos   = w_inc1;
                n_start = w_start;
                n_count = w_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_pos   <= '0;
            r_start <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/ini_section_locator_unit.sv -----
// Channel  Dir  Handshake                   Word
// -------  ---  --------------------------  ------------------------------------------
// in       in   i_in_valid / o_in_ready     i_data_byte, i_last_byte
// out      out  o_out_valid / i_out_ready   o_status, o_section_offset, o_section_length
// cfg      in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One byte per cycle unless the result stalls: an input register feeds the header
// matcher and section tracker, whose result for a file's last byte lands in an output register.
// A stalled result holds the output register; one more byte can wait in the input register.
// i_rst_n is synchronous, active low; it clears the match history, counters and valids.
module ini_section_locator_unit #(
    parameter int MAX_NAME_BYTES = isl_pkg::MAX_NAME_BYTES_DEF,
    parameter int OFFSET_BITS    = isl_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [isl_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last_byte,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [isl_pkg::STATUS_W-1:0]  o_status,
    output logic [isl_pkg::OUT_W-1:0]     o_section_offset,
    output logic [isl_pkg::OUT_W-1:0]     o_section_length,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [isl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [isl_pkg::CFG_W-1:0]     i_cfg_data
);
    import isl_pkg::*;

    logic [LEN_W-1:0]  r_name_len;
    logic [CFG_W-1:0]  r_name_low;
    logic [CFG_W-1:0]  r_name_high;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic              r_out_vld;
    t_result           r_out;

    t_step             w_step;
    logic              w_hit;
    t_result           w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len  <= '0;
            r_name_low  <= '0;
            r_name_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NAME_LEN:  r_name_len  <= i_cfg_data[LEN_W-1:0];
                CFG_NAME_LOW:  r_name_low  <= i_cfg_data;
                CFG_NAME_HIGH: r_name_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Word moves on when the output register is free or draining
    assign w_step.adv  = r_in_vld && (!r_out_vld || i_out_ready);
    assign w_step.last = r_in_last;
    assign o_in_ready  = !r_in_vld || w_step.adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    isl_match #(
        .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_name_len  (r_name_len),
        .i_name_low  (r_name_low),
        .i_name_high (r_name_high),
        .o_hit       (w_hit)
    );

    isl_track #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (r_in_byte),
        .i_hit        (w_hit),
        .i_name_empty (r_name_len == '0),
        .o_result     (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step.adv) begin
            r_out_vld <= r_in_last;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step.adv && r_in_last) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out.status;
    assign o_section_offset = r_out.offset;
    assign o_section_length = r_out.length;

`ifndef ASSERT_OFF
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step.adv && r_in_last |=> r_out_vld)
        else $error("last word did not produce a result");

    a_plain_word_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step.adv && !r_in_last |=> !r_out_vld)
        else $error("non-last word produced a result");

    a_in_reg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_step.adv |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held input word was overwritten");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status != ST_FOUND |-> r_out.offset == '0 && r_out.length == '0)
        else $error("offset or length nonzero on a failed search");
`endif

endmodule
